/* rtl/core/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define DCC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, held off during reset
`define DCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/core/dcc_pkg.sv */
// types and constants of the dimmer channel controller
package dcc_pkg;

    typedef enum logic [1:0] {
        CMD_BYTE = 2'd0,
        CMD_TICK = 2'd1,
        CMD_TEMP = 2'd2,
        CMD_ZERO = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        MODE_INIT  = 2'd0,
        MODE_RUN   = 2'd1,
        MODE_FAULT = 2'd2
    } t_mode;

    localparam logic [7:0] OP_SET_TARGET = 8'd1;
    localparam logic [7:0] OP_SET_RAMP   = 8'd2;
    localparam logic [7:0] OP_SET_LIMIT  = 8'd3;
    localparam logic [7:0] OP_RESET      = 8'd4;
    localparam logic [7:0] OP_GET_STATE  = 8'd5;
    localparam logic [7:0] OP_RESTART    = 8'd6;

    localparam logic [9:0]  LEVEL_MAX        = 10'd990;
    localparam logic [15:0] LEVEL_MAX_WIDE   = 16'd990;
    localparam logic [7:0]  BROADCAST_ID     = 8'h55;
    localparam logic [7:0]  ACK_BYTE         = 8'h06;
    localparam logic [7:0]  NAK_BYTE         = 8'h15;
    localparam logic [7:0]  TEMP_LIMIT_RESET = 8'd90;
    localparam logic [7:0]  ID_LIMIT         = 8'd16;

    localparam int unsigned REPLY_MAX = 8;

    // register index on the configuration port
    localparam logic REG_MODULE_ADDRESS = 1'b0;

    // everything one input item produces on the result side
    typedef struct packed {
        logic                  kind;
        logic [3:0]            count;
        logic [REPLY_MAX-1:0][7:0] bytes;
        logic [9:0]            level;
        logic [9:0]            target;
        logic                  fault;
    } t_burst;

endpackage

/* rtl/core/dcc_core.sv */
// channel state, packet framing and command execution
module dcc_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  logic [4:0]        i_addr,
    input  logic [1:0]        i_cmd,
    input  logic [7:0]        i_rx_data,
    input  logic signed [8:0] i_temperature,
    output dcc_pkg::t_burst   o_burst
);
    import dcc_pkg::*;

    t_mode           r_mode, n_mode;
    logic [9:0]      r_level, n_level;
    logic [9:0]      r_target, n_target;
    logic [7:0]      r_ramp, n_ramp;
    logic [7:0]      r_limit, n_limit;
    logic [7:0]      r_last_temp, n_last_temp;
    logic [7:0]      r_ticks, n_ticks;
    logic [2:0]      r_pkt_count, n_pkt_count;
    logic [3:0][7:0] r_pkt_bytes, n_pkt_bytes;

    logic [3:0][7:0] pkt_nb;
    logic [2:0]      cnt_inc;
    logic [2:0]      need;
    logic            keep;
    logic            done;
    logic [7:0]      id;
    logic [7:0]      op;
    logic            mine;
    logic            id_ok;
    logic [7:0]      ok_byte;
    logic [15:0]     target_raw;
    logic [7:0]      ticks_sat;
    logic [REPLY_MAX-1:0][7:0] rep;
    logic [3:0]      rep_n;
    logic            restart;

    // framing of the byte about to be taken
    always_comb begin
        pkt_nb = r_pkt_bytes;
        pkt_nb[r_pkt_count[1:0]] = i_rx_data;
        cnt_inc = r_pkt_count + 3'd1;
        need = 3'd3;
        keep = 1'b1;
        if (cnt_inc > 3'd1) begin
            unique case (pkt_nb[1])
                OP_SET_TARGET, OP_RESET:  need = 3'd4;
                OP_GET_STATE, OP_RESTART: need = 3'd2;
                OP_SET_RAMP, OP_SET_LIMIT: need = 3'd3;
                default:                  keep = 1'b0;
            endcase
        end
        done = keep && (cnt_inc >= need);
    end

    assign id         = pkt_nb[0];
    assign op         = pkt_nb[1];
    assign mine       = (id == {3'b000, i_addr});
    assign id_ok      = (id < ID_LIMIT) || (id == BROADCAST_ID);
    assign ok_byte    = (r_mode == MODE_FAULT) ? NAK_BYTE : ACK_BYTE;
    assign target_raw = {pkt_nb[2], pkt_nb[3]};
    assign ticks_sat  = (r_ticks == 8'hFF) ? r_ticks : r_ticks + 8'd1;

    always_comb begin
        n_mode      = r_mode;
        n_level     = r_level;
        n_target    = r_target;
        n_ramp      = r_ramp;
        n_limit     = r_limit;
        n_last_temp = r_last_temp;
        n_ticks     = r_ticks;
        n_pkt_count = r_pkt_count;
        n_pkt_bytes = r_pkt_bytes;
        rep         = '0;
        rep_n       = 4'd0;
        restart     = 1'b0;
        if (i_go) begin
            unique case (t_cmd'(i_cmd))
                CMD_BYTE: begin
                    n_pkt_bytes = pkt_nb;
                    n_pkt_count = keep ? cnt_inc : 3'd0;
                    if (done) begin
                        n_pkt_count = 3'd0;
                        if (id_ok) begin
                            unique case (op)
                                OP_SET_TARGET: if (mine) begin
                                    n_target = (target_raw > LEVEL_MAX_WIDE) ?
                                               LEVEL_MAX : target_raw[9:0];
                                    rep[0] = ok_byte;
                                    rep_n = 4'd1;
                                end
                                OP_SET_RAMP: if (mine) begin
                                    n_ramp = pkt_nb[2];
                                    rep[0] = ok_byte;
                                    rep_n = 4'd1;
                                end
                                OP_SET_LIMIT: if (mine) begin
                                    n_limit = pkt_nb[2];
                                    rep[0] = ok_byte;
                                    rep_n = 4'd1;
                                end
                                OP_RESET: if (mine) begin
                                    n_level  = 10'd0;
                                    n_target = 10'd0;
                                    n_ramp   = pkt_nb[2];
                                    n_limit  = pkt_nb[3];
                                    n_mode   = MODE_RUN;
                                    rep[0] = ACK_BYTE;
                                    rep_n = 4'd1;
                                end
                                OP_GET_STATE: if (mine && (id != 8'd0)) begin
                                    rep[0] = id;
                                    rep[1] = OP_GET_STATE;
                                    rep[2] = {6'b0, r_level[9:8]};
                                    rep[3] = r_level[7:0];
                                    rep[4] = r_ramp;
                                    rep[5] = r_last_temp;
                                    rep[6] = r_limit;
                                    rep[7] = {6'b0, r_mode};
                                    rep_n = 4'd8;
                                end
                                OP_RESTART: if (mine || (id == BROADCAST_ID)) begin
                                    restart = 1'b1;
                                    if (mine) begin
                                        rep[0] = ACK_BYTE;
                                        rep_n = 4'd1;
                                    end
                                end
                                default: ;
                            endcase
                        end
                        if (restart) begin
                            n_mode      = MODE_RUN;
                            n_level     = 10'd0;
                            n_target    = 10'd0;
                            n_ramp      = 8'd0;
                            n_limit     = TEMP_LIMIT_RESET;
                            n_last_temp = 8'd0;
                            n_ticks     = 8'd0;
                        end
                    end
                end
                CMD_TICK: begin
                    n_ticks = ticks_sat;
                    if ((r_mode != MODE_FAULT) && (ticks_sat >= r_ramp)) begin
                        n_ticks = 8'd0;
                        if (r_level < r_target) begin
                            n_level = r_level + 10'd1;
                        end else if (r_level > r_target) begin
                            n_level = r_level - 10'd1;
                        end
                    end
                end
                CMD_TEMP: begin
                    n_last_temp = i_temperature[7:0];
                    if (i_temperature > $signed({1'b0, r_limit})) begin
                        n_mode = MODE_FAULT;
                    end
                end
                CMD_ZERO: ;
                default: ;
            endcase
            // fault forces the output off after every non-byte item
            if ((t_cmd'(i_cmd) != CMD_BYTE) && (n_mode == MODE_FAULT)) begin
                n_level = 10'd0;
            end
        end
    end

    always_comb begin
        o_burst.kind   = (t_cmd'(i_cmd) != CMD_BYTE);
        o_burst.count  = (t_cmd'(i_cmd) == CMD_BYTE) ? rep_n : 4'd1;
        o_burst.bytes  = rep;
        o_burst.level  = n_level;
        o_burst.target = n_target;
        o_burst.fault  = (n_mode == MODE_FAULT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_RUN;
            r_level     <= 10'd0;
            r_target    <= 10'd0;
            r_ramp      <= 8'd0;
            r_limit     <= TEMP_LIMIT_RESET;
            r_last_temp <= 8'd0;
            r_ticks     <= 8'd0;
            r_pkt_count <= 3'd0;
        end else begin
            r_mode      <= n_mode;
            r_level     <= n_level;
            r_target    <= n_target;
            r_ramp      <= n_ramp;
            r_limit     <= n_limit;
            r_last_temp <= n_last_temp;
            r_ticks     <= n_ticks;
            r_pkt_count <= n_pkt_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pkt_bytes <= n_pkt_bytes;
    end

endmodule

/* rtl/core/dcc_burst.sv */
// result register that plays out the results of one item, one per cycle while i_ready is high
module dcc_burst (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  dcc_pkg::t_burst i_burst,
    output logic            o_free,
    output logic            o_valid,
    input  logic            i_ready,
    output logic            o_kind,
    output logic [7:0]      o_tx_data,
    output logic            o_last,
    output logic [9:0]      o_level,
    output logic [9:0]      o_target,
    output logic            o_fault,
    output logic [13:0]     o_on_time
);
    import dcc_pkg::*;

    logic       r_busy;
    logic [2:0] r_idx;
    t_burst     r_burst;
    logic       fire;
    logic       at_last;

    assign fire    = r_busy && i_ready;
    assign at_last = (({1'b0, r_idx} + 4'd1) == r_burst.count);
    assign o_free  = !r_busy || (fire && at_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 3'd0;
        end else if (i_load) begin
            r_busy <= (i_burst.count != 4'd0);
            r_idx  <= 3'd0;
        end else if (fire) begin
            if (at_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_burst <= i_burst;
        end
    end

    assign o_valid   = r_busy;
    assign o_kind    = r_burst.kind;
    assign o_tx_data = r_burst.bytes[r_idx];
    assign o_last    = at_last;
    assign o_level   = r_burst.level;
    assign o_target  = r_burst.target;
    assign o_fault   = r_burst.fault;
    assign o_on_time = {4'b0, r_burst.level} * 14'd10;

endmodule

/* rtl/core/dimmer_channel_controller.sv */
// top level of the addressed dimmer channel controller
// One phase-control dimmer channel on a shared serial bus. Each input transaction
// carries a received bus byte, a millisecond tick, a temperature sample or a zero
// crossing. Bytes are framed into packets (id, command, payload, 2 to 4 bytes by
// command) and an addressed packet sets the target level, the ramp period or the
// temperature limit, clears a fault, reads back the state or restarts the channel;
// the reply bytes (ACK 0x06, NAK 0x15 in fault, or the 8-byte state dump) come out
// one per output transaction with kind 0, the final one flagged by o_last. Ticks,
// samples and zero crossings each give one status transaction with kind 1. Every
// result also shows level, target, fault and the gate on-time (level x 10 us).
// An item goes through the input register, the command logic and the result
// register, which loads it once it is free and offers its first result. The block
// takes one item per cycle as long as each item yields at most one result and the
// sink keeps up; an item that yields several results holds the result register
// until its last result is taken, so a get-state request holds it for all 8 bytes.
// There is no start-up clearing pass.
// The channel address is the only register, at byte address 0 on the APB port.
module dimmer_channel_controller (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // input transactions
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_cmd,
    input  logic [7:0]        i_rx_data,
    input  logic signed [8:0] i_temperature,
    // result transactions
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_kind,
    output logic [7:0]        o_tx_data,
    output logic              o_last,
    output logic [9:0]        o_level,
    output logic [9:0]        o_target,
    output logic              o_fault,
    output logic [13:0]       o_on_time
);
    import dcc_pkg::*;

    // channel address, strapped through the configuration port
    logic [4:0]        r_module_address;
    // input register
    logic              r_in_valid;
    logic [1:0]        r_in_cmd;
    logic [7:0]        r_in_rx_data;
    logic signed [8:0] r_in_temperature;

    logic              advance;
    logic              burst_free;
    t_burst            burst;
    logic              cfg_write;

    // register write completes in the access phase
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_MODULE_ADDRESS) ? {27'b0, r_module_address} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_module_address <= 5'd0;
        end else if (cfg_write && (paddr[2] == REG_MODULE_ADDRESS)) begin
            r_module_address <= pwdata[4:0];
        end
    end

    // the held item moves on once the result register can take its results
    assign advance = r_in_valid && burst_free;
    // input register is free, or frees up this cycle
    assign o_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_cmd         <= i_cmd;
            r_in_rx_data     <= i_rx_data;
            r_in_temperature <= i_temperature;
        end
    end

    // state update and reply generation for the held item
    dcc_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_go          (advance),
        .i_addr        (r_module_address),
        .i_cmd         (r_in_cmd),
        .i_rx_data     (r_in_rx_data),
        .i_temperature (r_in_temperature),
        .o_burst       (burst)
    );

    // result register, plays out replies one transaction at a time
    dcc_burst u_burst (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (advance),
        .i_burst   (burst),
        .o_free    (burst_free),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_kind    (o_kind),
        .o_tx_data (o_tx_data),
        .o_last    (o_last),
        .o_level   (o_level),
        .o_target  (o_target),
        .o_fault   (o_fault),
        .o_on_time (o_on_time)
    );

endmodule

/* rtl/core/dcc_checker.sv */
// port-level checks of the dimmer channel controller and their binding
`include "assert_macros.svh"

module dcc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_kind,
    input logic        o_last,
    input logic [9:0]  o_level,
    input logic        o_fault,
    input logic [13:0] o_on_time
);

    // a stalled result stays offered
    `DCC_ASSERT_NEXT(a_hold_stalled, i_clk, i_rst_n, o_valid && !i_ready, o_valid)

    // a status report is always the only result of its item
    `DCC_ASSERT_IMPLY(a_status_single, i_clk, i_rst_n, o_valid && o_kind, o_last)

    // a latched fault keeps the lamp dark
    `DCC_ASSERT_IMPLY(a_fault_dark, i_clk, i_rst_n, o_valid && o_fault, o_level == 10'd0)

    // on-time follows the level
    `DCC_ASSERT_IMPLY(a_on_time, i_clk, i_rst_n, o_valid, o_on_time == ({4'b0, o_level} * 14'd10))

endmodule

bind dimmer_channel_controller dcc_checker u_checker (.*);
